/* rtl/core/lrupr_pkg.sv */
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_W    = 16;
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = IDX_W;
  localparam int CNT_W     = $clog2(FRAMES + 1);
  localparam int CFG_W     = 4;
  localparam int FAULT_W   = 24;

  localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(FRAMES - 1);
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(FRAMES);

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              end_of_sequence;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   frame_index;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_count;
    logic               last;
  } res_t;

endpackage

/* rtl/core/lrupr_in_if.sv */
`timescale 1ns / 1ps

interface lrupr_in_if;
  import lrupr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_number;
  logic              end_of_sequence;

  modport source (output valid, output page_number, output end_of_sequence, input ready);
  modport sink   (input valid, input page_number, input end_of_sequence, output ready);
endinterface

/* rtl/core/lrupr_out_if.sv */
`timescale 1ns / 1ps

interface lrupr_out_if;
  import lrupr_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [IDX_W-1:0]   frame_index;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_count;
  logic               last;

  modport source (
    output valid, output hit, output frame_index, output evicted_valid,
    output evicted_page, output fault_count, output last, input ready
  );
  modport sink (
    input valid, input hit, input frame_index, input evicted_valid,
    input evicted_page, input fault_count, input last, output ready
  );
endinterface

/* rtl/core/lrupr_in_reg.sv */
`timescale 1ns / 1ps

module lrupr_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  lrupr_in_if.sink        in_i,
  input  logic            take_i,
  output logic            valid_o,
  output lrupr_pkg::item_t item_o
);
  import lrupr_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  load;

  // room when empty or when the held item moves on this cycle
  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d              = 1'b1;
      item_d.page_number   = in_i.page_number;
      item_d.end_of_sequence = in_i.end_of_sequence;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

/* rtl/core/lrupr_frames.sv */
`timescale 1ns / 1ps

module lrupr_frames (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lrupr_pkg::CFG_W-1:0] frames_in_use_i,
  input  lrupr_pkg::item_t           item_i,
  input  logic                       take_i,
  output lrupr_pkg::res_t            res_o,
  output logic [lrupr_pkg::CNT_W-1:0] n_eff_o
);
  import lrupr_pkg::*;

  logic [PAGE_W-1:0]  page_q [FRAMES];
  logic [FRAMES-1:0]  valid_q, valid_d;
  logic [RANK_W-1:0]  rank_q [FRAMES];
  logic [RANK_W-1:0]  rank_d [FRAMES];
  logic [FAULT_W-1:0] fault_q, fault_d;

  logic [CNT_W-1:0]   n_eff;
  logic [FRAMES-1:0]  in_use, match, free;
  logic               hit, have_free;
  logic [IDX_W-1:0]   hit_idx, free_idx, vic_idx, slot;
  logic [RANK_W-1:0]  best, hit_rank;

  // clamp frame count to 1..FRAMES
  always_comb begin
    if (frames_in_use_i == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(frames_in_use_i) > CNT_W'(FRAMES) ||
                 (CFG_W > CNT_W && (frames_in_use_i >> CNT_W) != '0)) begin
      n_eff = CNT_W'(FRAMES);
    end else begin
      n_eff = CNT_W'(frames_in_use_i);
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      in_use[i] = CNT_W'(i) < n_eff;
      match[i]  = in_use[i] && valid_q[i] && (page_q[i] == item_i.page_number);
      free[i]   = in_use[i] && !valid_q[i];
    end
  end

  // lowest-indexed match and free frame
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (free[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // oldest frame, lowest index on ties
  always_comb begin
    best    = '0;
    vic_idx = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (in_use[i] && rank_q[i] > best) begin
        best    = rank_q[i];
        vic_idx = IDX_W'(i);
      end
    end
  end

  assign hit       = |match;
  assign have_free = |free;
  assign hit_rank  = rank_q[hit_idx];

  always_comb begin
    if (hit) begin
      slot = hit_idx;
    end else if (have_free) begin
      slot = free_idx;
    end else begin
      slot = vic_idx;
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_d[i] = rank_q[i];
      if (IDX_W'(i) == slot) begin
        rank_d[i] = '0;
      end else if (in_use[i] && valid_q[i]) begin
        if (hit) begin
          if (rank_q[i] < hit_rank) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end else if (rank_q[i] < RANK_MAX) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
    end
    valid_d       = valid_q;
    valid_d[slot] = 1'b1;
    if (hit || fault_q == FAULT_MAX) begin
      fault_d = fault_q;
    end else begin
      fault_d = fault_q + FAULT_W'(1);
    end
  end

  always_comb begin
    res_o.hit           = hit;
    res_o.frame_index   = slot;
    res_o.evicted_valid = !hit && !have_free;
    res_o.evicted_page  = (!hit && !have_free) ? page_q[slot] : '0;
    res_o.fault_count   = fault_d;
    res_o.last          = item_i.end_of_sequence;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fault_q <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (take_i) begin
      if (item_i.end_of_sequence) begin
        valid_q <= '0;
        fault_q <= '0;
        for (int i = 0; i < FRAMES; i++) begin
          rank_q[i] <= '0;
        end
      end else begin
        valid_q <= valid_d;
        fault_q <= fault_d;
        for (int i = 0; i < FRAMES; i++) begin
          rank_q[i] <= rank_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      page_q[slot] <= item_i.page_number;
    end
  end

  assign n_eff_o = n_eff;
endmodule

/* rtl/core/lru_page_replacement.sv */
`timescale 1ns / 1ps

// channel  dir  handshake     payload
// in_i     in   valid/ready   page_number, end_of_sequence
// out_o    out  valid/ready   hit, frame_index, evicted_valid, evicted_page,
//                             fault_count, last
// cfg      in   cfg_we_i      cfg_wdata_i -> frames_in_use
//
// one reference per cycle sustained while the output is ready; the lookup,
// victim choice and rank update are combinational between the input register
// and the result register; the result register loads as an item leaves the
// input register, and out_o shows that registered result
// reset clears all frame valid bits, ranks and the fault count, and sets
// frames_in_use to 8; no clearing pass is needed
// a stalled output holds its result; one more item waits in the input register

module lru_page_replacement (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata_i,
  lrupr_in_if.sink                   in_i,
  lrupr_out_if.source                out_o
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0] frames_in_use_q;
  logic             in_valid;
  item_t            in_item;
  logic             take;
  res_t             res, res_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] n_eff;

  assign take = in_valid && (!out_valid_q || out_o.ready);

  lrupr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  lrupr_frames u_frames (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_in_use_i (frames_in_use_q),
    .item_i          (in_item),
    .take_i          (take),
    .res_o           (res),
    .n_eff_o         (n_eff)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_RESET;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frames_in_use_q <= cfg_wdata_i;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.hit           = res_q.hit;
  assign out_o.frame_index   = res_q.frame_index;
  assign out_o.evicted_valid = res_q.evicted_valid;
  assign out_o.evicted_page  = res_q.evicted_page;
  assign out_o.fault_count   = res_q.fault_count;
  assign out_o.last          = res_q.last;

`ifndef ASSERT_OFF
  // the chosen frame always lies among the frames in use
  a_slot_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> (CNT_W'(res.frame_index) < n_eff))
    else $error("frame index beyond frames in use");

  // an eviction only happens on a fault
  a_evict_on_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.evicted_valid |-> !res_q.hit)
    else $error("eviction reported on a hit");

  // a held input item stays put until it moves to the result register
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !take |=> in_valid && $stable(in_item))
    else $error("waiting input item lost or changed");

  // a hit within a sequence leaves the fault count unchanged
  a_hit_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && res.hit && !in_item.end_of_sequence ##1 take |->
      res.hit ? (res.fault_count == $past(res.fault_count)) : 1'b1)
    else $error("fault count moved on a hit");
`endif
endmodule
